/* design/tdst_pkg.sv */
// Package: shared types, request codes and sizes for the soft timer bank.
`timescale 1ns / 1ps
package tdst_pkg;

  parameter int NUM_CHANNELS_DEF = 5;
  parameter int COUNT_WIDTH_DEF  = 16;

  parameter int NUM_REGS   = 5;
  parameter int PERIOD_W   = 16;
  parameter int REQ_W      = 2;
  parameter int CH_W       = 3;
  parameter int LOAD_W     = 16;
  parameter int MASK_W     = 5;
  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_OS  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLR_OS   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLR_PD   = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CH_W-1:0]   channel;
    logic [LOAD_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] due_mask;
    logic [MASK_W-1:0] expired_mask;
    logic              flag_value;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic clr_os;
    logic clr_pd;
  } chan_cmd_t;

  typedef struct packed {
    logic due;
    logic expired;
    logic pd_flag;
    logic os_flag;
  } chan_stat_t;

endpackage

/* design/tick_driven_soft_timer_bank_core.sv */
// Top level: soft timer bank with request register, channel slices and result register.
// A request transferred on start is held in the request register, and its result in the
// result register, from which it shows on out_data with out_strobe.
// Throughput: one request per cycle; busy is always low, each request is registered once
// and applied to the channel slices in one pass.
// Reset (synchronous, rst_n low): clears all counters, flags, period registers and strobes.
// The receiver cannot stall: every result is marked by out_strobe for exactly one cycle.
`timescale 1ns / 1ps
module tick_driven_soft_timer_bank_core #(
  parameter int NUM_CHANNELS = tdst_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = tdst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  tdst_pkg::in_item_t               in_data,
  // result channel
  output logic                             out_strobe,
  output tdst_pkg::out_item_t              out_data,
  // configuration port
  input  logic                             cfg_we,
  input  logic [tdst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdst_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tdst_pkg::*;

  localparam int LW = (COUNT_WIDTH > LOAD_W) ? COUNT_WIDTH : LOAD_W;

  // Period registers, one per configured channel.
  logic [PERIOD_W-1:0] period_r [NUM_REGS];

  // Request register: holds the transfer for processing.
  in_item_t  req_r;
  logic      req_vld_r;

  // Result register.
  out_item_t out_r, out_nxt;
  logic      out_vld_r;

  chan_cmd_t  cmd  [NUM_CHANNELS];
  chan_stat_t stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sel;

  logic [LW-1:0]          load_ext;
  logic [COUNT_WIDTH-1:0] load_cnt;

  // No back-pressure: every request is taken as it arrives.
  assign busy = 1'b0;

  // Truncate or zero-extend the load value to the counter width.
  assign load_ext = LW'(req_r.load_value);
  assign load_cnt = load_ext[COUNT_WIDTH-1:0];

  // Write period registers; drop writes beyond the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        period_r[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          period_r[i] <= cfg_data[PERIOD_W-1:0];
        end
      end
    end
  end

  // Capture the request on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= in_data;
    end
  end

  // Decode the request into per-channel commands. A channel index past the bank matches no
  // slice, so a load or clear is dropped and its result is all zero; a tick ignores the index.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      sel[c]        = (req_r.channel == CH_W'(c));
      cmd[c].tick   = req_vld_r && (req_r.req_type == REQ_TICK);
      cmd[c].load   = req_vld_r && (req_r.req_type == REQ_LOAD_OS) && sel[c];
      cmd[c].clr_os = req_vld_r && (req_r.req_type == REQ_CLR_OS) && sel[c];
      cmd[c].clr_pd = req_vld_r && (req_r.req_type == REQ_CLR_PD) && sel[c];
    end
  end

  // Channel slices; channels without a period register get a zero period, which disables their periodic counter.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic [PERIOD_W-1:0] chan_period;
    if (c < NUM_REGS) begin : g_reg
      assign chan_period = period_r[c];
    end else begin : g_noreg
      assign chan_period = '0;
    end

    tdst_chan #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .period     (chan_period),
      .cmd        (cmd[c]),
      .load_value (load_cnt),
      .stat       (stat[c])
    );
  end

  // Build the result: masks on a tick, the pre-clear flag on a clear, all zero on a load.
  always_comb begin
    out_nxt = '0;
    unique case (req_r.req_type)
      REQ_TICK: begin
        for (int c = 0; c < MASK_W && c < NUM_CHANNELS; c++) begin
          out_nxt.due_mask[c]     = stat[c].due;
          out_nxt.expired_mask[c] = stat[c].expired;
        end
      end
      REQ_CLR_OS: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          out_nxt.flag_value = out_nxt.flag_value | (sel[c] & stat[c].os_flag);
        end
      end
      REQ_CLR_PD: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          out_nxt.flag_value = out_nxt.flag_value | (sel[c] & stat[c].pd_flag);
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  // Mark each result with the strobe for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

/* design/tdst_chan.sv */
// One timer channel: a periodic up counter and a one-shot down counter with sticky flags.
`timescale 1ns / 1ps
module tdst_chan #(
  parameter int COUNT_WIDTH = tdst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tdst_pkg::PERIOD_W-1:0] period,
  input  tdst_pkg::chan_cmd_t          cmd,
  input  logic [COUNT_WIDTH-1:0]       load_value,
  output tdst_pkg::chan_stat_t         stat
);
  import tdst_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH + 1 > PERIOD_W) ? COUNT_WIDTH + 1 : PERIOD_W;

  logic [COUNT_WIDTH-1:0] pd_cnt_r, pd_cnt_nxt;
  logic                   pd_flag_r, pd_flag_nxt;
  logic [COUNT_WIDTH-1:0] os_cnt_r, os_cnt_nxt;
  logic                   os_flag_r, os_flag_nxt;

  logic [COUNT_WIDTH:0]   pd_inc;
  logic [CMP_W-1:0]       pd_inc_ext;
  logic [CMP_W-1:0]       per_ext;
  logic                   pd_en;
  logic                   pd_wrap;
  logic                   os_run;
  logic                   os_exp;

  always_comb begin
    pd_inc     = {1'b0, pd_cnt_r} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    pd_inc_ext = CMP_W'(pd_inc);
    per_ext    = CMP_W'(period);
    pd_en      = (period != '0);
    pd_wrap    = cmd.tick && pd_en && (pd_inc_ext >= per_ext);
    os_run     = (os_cnt_r != '0);
    os_exp     = cmd.tick && (os_cnt_r == COUNT_WIDTH'(1));

    pd_cnt_nxt = pd_cnt_r;
    if (cmd.tick) begin
      if (!pd_en || pd_wrap) begin
        pd_cnt_nxt = '0;
      end else begin
        pd_cnt_nxt = pd_inc[COUNT_WIDTH-1:0];
      end
    end

    pd_flag_nxt = pd_flag_r;
    if (cmd.clr_pd) begin
      pd_flag_nxt = 1'b0;
    end else if (pd_wrap) begin
      pd_flag_nxt = 1'b1;
    end

    os_cnt_nxt = os_cnt_r;
    if (cmd.load) begin
      os_cnt_nxt = load_value;
    end else if (cmd.tick && os_run) begin
      os_cnt_nxt = os_cnt_r - COUNT_WIDTH'(1);
    end

    os_flag_nxt = os_flag_r;
    if (cmd.clr_os) begin
      os_flag_nxt = 1'b0;
    end else if (os_exp) begin
      os_flag_nxt = 1'b1;
    end

    stat.due     = pd_wrap;
    stat.expired = os_exp;
    stat.pd_flag = pd_flag_r;
    stat.os_flag = os_flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_cnt_r  <= '0;
      pd_flag_r <= 1'b0;
      os_cnt_r  <= '0;
      os_flag_r <= 1'b0;
    end else begin
      pd_cnt_r  <= pd_cnt_nxt;
      pd_flag_r <= pd_flag_nxt;
      os_cnt_r  <= os_cnt_nxt;
      os_flag_r <= os_flag_nxt;
    end
  end

endmodule
